// File: design/r16tm_pkg.sv
//------------------------------------------------------------------------------
// Radix trie map package
// Shared types and constants for the radix trie map.
//------------------------------------------------------------------------------
`default_nettype none

package r16tm_pkg;

   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;

   // Slot value written by remove and returned by get on a missing path.
   localparam logic signed [VALUE_W-1:0] MISSING_VALUE = -32'sd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_GET    = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_CHECK,
      ST_ALLOC,
      ST_SWEEP,
      ST_LEAF,
      ST_LEAF_RD
   } state_type;

endpackage

`default_nettype wire

// File: design/r16tm_ram.sv
//------------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
//------------------------------------------------------------------------------
`default_nettype none

module r16tm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/radix16_trie_map_top.sv
//------------------------------------------------------------------------------
// Radix trie map
// Sparse map from a 32-bit key to a signed 32-bit value held as a radix trie.
//------------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// word appears for one cycle with rsp_valid, and busy drops in that same
// cycle. The walk down the pointer memory makes one dependent read per
// branch level; a get adds a read of the leaf slot. An add that stops at a
// missing child and finds room in the pools builds the path with one new
// node per missing level, then clears all 2^RADIX_BITS slots of the new
// leaf while writing the value. There is no clearing pass after reset: the
// root's child-valid row sits in flip-flops and every other row is written
// when its node is made.
`default_nettype none

module radix16_trie_map_top import r16tm_pkg::*; #(
   parameter int LEVELS      = 8,
   parameter int RADIX_BITS  = 4,
   parameter int BRANCH_POOL = 1024,
   parameter int LEAF_POOL   = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [CMD_W-1:0]          req_cmd,
   input  logic [KEY_W-1:0]          req_key,
   input  logic signed [VALUE_W-1:0] req_value_in,
   output logic                      rsp_valid,
   output logic signed [VALUE_W-1:0] rsp_value_out,
   output logic                      rsp_pool_full,
   output logic                      rsp_path_found
);

   localparam int FANOUT = 1 << RADIX_BITS;
   localparam int KW     = LEVELS * RADIX_BITS;
   localparam int LV_W   = $clog2(LEVELS);
   localparam int BN_W   = $clog2(BRANCH_POOL);
   localparam int LN_W   = $clog2(LEAF_POOL);
   localparam int PTR_W  = (BN_W > LN_W) ? BN_W : LN_W;
   localparam int NB_W   = $clog2(BRANCH_POOL + 1);
   localparam int NL_W   = $clog2(LEAF_POOL + 1);
   localparam int PA_W   = BN_W + RADIX_BITS;
   localparam int LA_W   = LN_W + RADIX_BITS;
   localparam logic [LV_W-1:0] LAST_BRANCH = LV_W'(LEVELS - 2);

   state_type                  state_ff, state_in;
   logic [CMD_W-1:0]           cmd_ff, cmd_in;
   logic [KW-1:0]              key_ff, key_in;
   logic signed [VALUE_W-1:0]  val_ff, val_in;
   logic [LV_W-1:0]            level_ff, level_in;
   logic [PTR_W-1:0]           node_ff, node_in;
   logic [FANOUT-1:0]          row_ff, row_in;
   logic                       first_ff, first_in;
   logic [RADIX_BITS-1:0]      sweep_ff, sweep_in;
   logic [NB_W-1:0]            next_branch_ff, next_branch_in;
   logic [NL_W-1:0]            next_leaf_ff, next_leaf_in;
   logic [FANOUT-1:0]          root_row_ff, root_row_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]  rsp_value_out_ff, rsp_value_out_in;
   logic                       rsp_pool_full_ff, rsp_pool_full_in;
   logic                       rsp_path_found_ff, rsp_path_found_in;

   logic                       ptr_we, ptr_re;
   logic [PA_W-1:0]            ptr_waddr, ptr_raddr;
   logic [PTR_W-1:0]           ptr_wdata, ptr_rdata;
   logic                       row_we, row_re;
   logic [BN_W-1:0]            row_waddr, row_raddr;
   logic [FANOUT-1:0]          row_wdata, row_rdata;
   logic                       leaf_we, leaf_re;
   logic [LA_W-1:0]            leaf_waddr, leaf_raddr;
   logic [VALUE_W-1:0]         leaf_wdata, leaf_rdata;

   logic [KW-1:0]              key_ext;
   logic [RADIX_BITS-1:0]      digit_at [LEVELS];
   logic [RADIX_BITS-1:0]      digit_cur, digit_nxt, leaf_digit;
   logic [LV_W-1:0]            level_nxt;
   logic [FANOUT-1:0]          cur_row, onehot, new_row;
   logic [PTR_W-1:0]           fresh;
   logic [LV_W-1:0]            need;
   logic                       pool_short;

   r16tm_ram #(.WIDTH(PTR_W), .DEPTH(BRANCH_POOL * FANOUT)) u_ptr_ram (
      .clock (clock),
      .we    (ptr_we),
      .waddr (ptr_waddr),
      .wdata (ptr_wdata),
      .re    (ptr_re),
      .raddr (ptr_raddr),
      .rdata (ptr_rdata)
   );

   r16tm_ram #(.WIDTH(FANOUT), .DEPTH(BRANCH_POOL)) u_row_ram (
      .clock (clock),
      .we    (row_we),
      .waddr (row_waddr),
      .wdata (row_wdata),
      .re    (row_re),
      .raddr (row_raddr),
      .rdata (row_rdata)
   );

   r16tm_ram #(.WIDTH(VALUE_W), .DEPTH(LEAF_POOL * FANOUT)) u_leaf_ram (
      .clock (clock),
      .we    (leaf_we),
      .waddr (leaf_waddr),
      .wdata (leaf_wdata),
      .re    (leaf_re),
      .raddr (leaf_raddr),
      .rdata (leaf_rdata)
   );

   // Digits above bit 31 read as zero; key bits above the trie depth are unused.
   assign key_ext = KW'(req_key);

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         digit_at[l] = key_ff[(LEVELS - 1 - l) * RADIX_BITS +: RADIX_BITS];
      end
   end

   assign level_nxt  = LV_W'(level_ff + 1'b1);
   assign digit_cur  = digit_at[level_ff];
   assign digit_nxt  = digit_at[level_nxt];
   assign leaf_digit = digit_at[LEVELS - 1];

   // The root row lives in flip-flops; every other branch row is in memory.
   assign cur_row = (level_ff == '0) ? root_row_ff : row_rdata;
   assign onehot  = FANOUT'(1) << digit_cur;
   assign new_row = first_ff ? (row_ff | onehot) : onehot;
   assign fresh   = (level_ff == LAST_BRANCH) ? PTR_W'(next_leaf_ff) : PTR_W'(next_branch_ff);

   assign need       = LAST_BRANCH - level_ff;
   assign pool_short = (({1'b0, next_branch_ff} + (NB_W + 1)'(need)) >
                        (NB_W + 1)'(BRANCH_POOL)) ||
                       (next_leaf_ff >= NL_W'(LEAF_POOL));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         next_branch_ff <= NB_W'(1);
         next_leaf_ff   <= '0;
         root_row_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         next_branch_ff <= next_branch_in;
         next_leaf_ff   <= next_leaf_in;
         root_row_ff    <= root_row_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff            <= cmd_in;
      key_ff            <= key_in;
      val_ff            <= val_in;
      level_ff          <= level_in;
      node_ff           <= node_in;
      row_ff            <= row_in;
      first_ff          <= first_in;
      sweep_ff          <= sweep_in;
      rsp_value_out_ff  <= rsp_value_out_in;
      rsp_pool_full_ff  <= rsp_pool_full_in;
      rsp_path_found_ff <= rsp_path_found_in;
   end

   always_comb begin
      state_in          = state_ff;
      cmd_in            = cmd_ff;
      key_in            = key_ff;
      val_in            = val_ff;
      level_in          = level_ff;
      node_in           = node_ff;
      row_in            = row_ff;
      first_in          = first_ff;
      sweep_in          = sweep_ff;
      next_branch_in    = next_branch_ff;
      next_leaf_in      = next_leaf_ff;
      root_row_in       = root_row_ff;
      rsp_valid_in      = 1'b0;
      rsp_value_out_in  = '0;
      rsp_pool_full_in  = 1'b0;
      rsp_path_found_in = 1'b0;

      ptr_we     = 1'b0;
      ptr_waddr  = {node_ff[BN_W-1:0], digit_cur};
      ptr_wdata  = fresh;
      ptr_re     = 1'b0;
      ptr_raddr  = {ptr_rdata[BN_W-1:0], digit_nxt};
      row_we     = 1'b0;
      row_waddr  = node_ff[BN_W-1:0];
      row_wdata  = new_row;
      row_re     = 1'b0;
      row_raddr  = ptr_rdata[BN_W-1:0];
      leaf_we    = 1'b0;
      leaf_waddr = {node_ff[LN_W-1:0], leaf_digit};
      leaf_wdata = val_ff;
      leaf_re    = 1'b0;
      leaf_raddr = {node_ff[LN_W-1:0], leaf_digit};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in    = req_cmd;
               key_in    = key_ext;
               val_in    = req_value_in;
               level_in  = '0;
               node_in   = '0;
               ptr_re    = 1'b1;
               ptr_raddr = {{BN_W{1'b0}}, key_ext[KW-1 -: RADIX_BITS]};
               state_in  = ST_WALK;
            end
         end

         // Pointer data for the current level is on the RAM output; a valid
         // child sends its pointer straight back as the next read address.
         ST_WALK: begin
            if (!cur_row[digit_cur]) begin
               row_in   = cur_row;
               state_in = ST_CHECK;
            end else begin
               node_in = ptr_rdata;
               if (level_ff == LAST_BRANCH) begin
                  state_in = ST_LEAF;
               end else begin
                  level_in = level_nxt;
                  ptr_re   = 1'b1;
                  row_re   = 1'b1;
               end
            end
         end

         ST_CHECK: begin
            if (cmd_ff == CMD_ADD && !pool_short) begin
               first_in = 1'b1;
               state_in = ST_ALLOC;
            end else begin
               rsp_valid_in     = 1'b1;
               rsp_pool_full_in = (cmd_ff == CMD_ADD);
               if (cmd_ff == CMD_GET) begin
                  rsp_value_out_in = MISSING_VALUE;
               end
               state_in = ST_IDLE;
            end
         end

         // One new child per cycle, from the missing level down to the leaf.
         ST_ALLOC: begin
            ptr_we   = 1'b1;
            first_in = 1'b0;
            node_in  = fresh;
            if (level_ff == '0) begin
               root_row_in = new_row;
            end else begin
               row_we = 1'b1;
            end
            if (level_ff == LAST_BRANCH) begin
               next_leaf_in = next_leaf_ff + NL_W'(1);
               sweep_in     = '0;
               state_in     = ST_SWEEP;
            end else begin
               next_branch_in = next_branch_ff + NB_W'(1);
               level_in       = level_nxt;
            end
         end

         // Clear the new leaf, dropping the value into its own slot on the way.
         ST_SWEEP: begin
            leaf_we    = 1'b1;
            leaf_waddr = {node_ff[LN_W-1:0], sweep_ff};
            leaf_wdata = (sweep_ff == leaf_digit) ? val_ff : '0;
            if (sweep_ff == {RADIX_BITS{1'b1}}) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + RADIX_BITS'(1);
            end
         end

         ST_LEAF: begin
            priority if (cmd_ff == CMD_GET) begin
               leaf_re  = 1'b1;
               state_in = ST_LEAF_RD;
            end else if (cmd_ff == CMD_ADD) begin
               leaf_we           = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_path_found_in = 1'b1;
               state_in          = ST_IDLE;
            end else if (cmd_ff == CMD_REMOVE) begin
               leaf_we           = 1'b1;
               leaf_wdata        = MISSING_VALUE;
               rsp_valid_in      = 1'b1;
               rsp_path_found_in = 1'b1;
               state_in          = ST_IDLE;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         ST_LEAF_RD: begin
            rsp_valid_in      = 1'b1;
            rsp_value_out_in  = leaf_rdata;
            rsp_path_found_in = 1'b1;
            state_in          = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_out  = rsp_value_out_ff;
   assign rsp_pool_full  = rsp_pool_full_ff;
   assign rsp_path_found = rsp_path_found_ff;

endmodule

`default_nettype wire
